/* src/rdft_pkg.sv */
// shared types, constants and the arctangent table for the one-sided real dft block
package rdft_pkg;

    localparam int SAMPLE_W = 16;
    localparam int TW_W     = 18;
    localparam int BIN_W    = 6;
    localparam int PART_W   = 26;
    localparam int MAG_W    = 25;
    localparam int POW_W    = 50;
    localparam int PHASE_W  = 16;
    localparam int XY_W     = 48;
    localparam int Z_W      = 36;
    localparam int STEP_W   = 5;
    localparam int CORDIC_LAST = 23;

    typedef logic signed [XY_W-1:0]    xy_t;
    typedef logic signed [Z_W-1:0]     z_t;
    typedef logic signed [PART_W-1:0]  part_t;
    typedef logic signed [TW_W-1:0]    tw_t;
    typedef logic signed [PHASE_W-1:0] phase_t;

    localparam xy_t    CORDIC_K    = 48'sd652032874;
    localparam z_t     HALF_PI_Q30 = 36'sd1686629713;
    localparam z_t     PI_Q30      = 36'sd3373259426;
    localparam tw_t    TW_LIM      = 18'sd65536;
    localparam logic [MAG_W-1:0] PART_LIM_U = 25'd16777216;
    localparam logic [MAG_W-1:0] MAG_LIM    = 25'd23726566;
    localparam phase_t PHASE_LIM   = 16'sd25736;
    localparam phase_t HALF_PI_Q13 = 16'sd12868;

    // atan(2^-i) in radians, Q30
    function automatic z_t atan_q30(input logic [STEP_W-1:0] i);
        z_t v;
        unique case (i)
            5'd0:    v = 36'sh03243F6A8;
            5'd1:    v = 36'sh01DAC6705;
            5'd2:    v = 36'sh00FADBAFC;
            5'd3:    v = 36'sh007F56EA6;
            5'd4:    v = 36'sh003FEAB76;
            5'd5:    v = 36'sh001FFD55B;
            5'd6:    v = 36'sh000FFFAAA;
            5'd7:    v = 36'sh0007FFF55;
            5'd8:    v = 36'sh0003FFFEA;
            5'd9:    v = 36'sh0001FFFFD;
            5'd10:   v = 36'sh0000FFFFF;
            5'd11:   v = 36'sh00007FFFF;
            5'd12:   v = 36'sh00003FFFF;
            5'd13:   v = 36'sh00001FFFF;
            5'd14:   v = 36'sh00000FFFF;
            5'd15:   v = 36'sh000007FFF;
            5'd16:   v = 36'sh000003FFF;
            5'd17:   v = 36'sh000001FFF;
            5'd18:   v = 36'sh000000FFF;
            5'd19:   v = 36'sh0000007FF;
            5'd20:   v = 36'sh0000003FF;
            5'd21:   v = 36'sh0000001FF;
            5'd22:   v = 36'sh0000000FF;
            5'd23:   v = 36'sh00000007F;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

/* src/rdft_ram.sv */
// generic single-port-write ram with registered read
module rdft_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                                      clk,
    input  logic                                      wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                          wr_data,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                          rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

/* src/real_dft_one_sided_spectrum.sv */
// one-sided real dft spectrum: frame store, shared mac, reciprocal scaling, square root and cordic
//
// samples are taken one per transfer (start high while busy is low) into a frame
// store of FRAME_LEN entries. after the last sample of a frame, busy rises and the
// block computes bins 0 to FRAME_LEN/2 by a direct dft, one bin after another, and
// shows each bin on the result ports for one cycle with result_strobe high; the
// receiver cannot stall, so every strobed cycle must be captured. last_bin marks
// the final bin, after which busy falls and the next frame may be loaded.
// after reset the block first builds a cos/sin table with a rotation cordic while busy is
// high. per bin the work is one mac pass over the frame store at one sample per cycle, a
// shared reciprocal multiply for the 1/N and 2/N scaling, squaring of both parts, a
// bit-serial square root and a 24-step vectoring cordic for the phase, which is skipped
// when the phase is a special case. the cordic shift-add unit is shared between the
// table build and the phase.
module real_dft_one_sided_spectrum #(
    parameter int FRAME_LEN = 64
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic signed [rdft_pkg::SAMPLE_W-1:0] sample,
    output logic                                result_strobe,
    output logic [rdft_pkg::BIN_W-1:0]          bin_index,
    output logic signed [rdft_pkg::PART_W-1:0]  real_part,
    output logic signed [rdft_pkg::PART_W-1:0]  imag_part,
    output logic [rdft_pkg::MAG_W-1:0]          magnitude,
    output logic [rdft_pkg::POW_W-1:0]          power,
    output logic signed [rdft_pkg::PHASE_W-1:0] phase,
    output logic                                phase_valid,
    output logic                                last_bin
);

    localparam int AW      = (FRAME_LEN > 1) ? $clog2(FRAME_LEN) : 1;
    localparam int HALF    = FRAME_LEN / 2;
    localparam int ACC_W   = 41;
    localparam int DV_W    = 48;
    localparam int DIV_D   = FRAME_LEN * 256;
    localparam int RND_ADD = FRAME_LEN * 128;
    // 4 * (pi/2 in Q30) split as TW_A * FRAME_LEN + TW_B
    localparam longint TW_A = (4 * 64'd1686629713) / FRAME_LEN;
    localparam longint TW_B = (4 * 64'd1686629713) % FRAME_LEN;
    localparam int Z_W  = rdft_pkg::Z_W;
    localparam int XY_W = rdft_pkg::XY_W;
    // floor(v / N) for any 32-bit v as (v * RCP) >> RCP_SH
    localparam int     RCP_SH = 32 + $clog2(FRAME_LEN);
    localparam longint RCP    = ((64'd1 << RCP_SH) / FRAME_LEN) + 1;

    // sequencer states
    localparam logic [3:0] S_INIT_LOAD = 4'd0;
    localparam logic [3:0] S_INIT_ROT  = 4'd1;
    localparam logic [3:0] S_INIT_WR   = 4'd2;
    localparam logic [3:0] S_IDLE      = 4'd3;
    localparam logic [3:0] S_MAC       = 4'd4;
    localparam logic [3:0] S_DIV_LOAD  = 4'd5;
    localparam logic [3:0] S_DIV       = 4'd6;
    localparam logic [3:0] S_FIX       = 4'd7;
    localparam logic [3:0] S_SQ1       = 4'd8;
    localparam logic [3:0] S_SQ2       = 4'd9;
    localparam logic [3:0] S_SQ3       = 4'd10;
    localparam logic [3:0] S_SQRT      = 4'd11;
    localparam logic [3:0] S_PH_LOAD   = 4'd12;
    localparam logic [3:0] S_PH_ROT    = 4'd13;
    localparam logic [3:0] S_PH_END    = 4'd14;
    localparam logic [3:0] S_OUT       = 4'd15;

    localparam logic [AW:0]   N_X    = (AW+1)'(FRAME_LEN);
    localparam logic [AW-1:0] N_LAST = AW'(FRAME_LEN - 1);
    localparam logic [AW-1:0] K_LAST = AW'(HALF);
    localparam logic [AW+1:0] N_R    = (AW+2)'(FRAME_LEN);
    localparam logic [AW+1:0] N2_R   = (AW+2)'(2 * FRAME_LEN);
    localparam rdft_pkg::z_t  TW_A_Z = Z_W'(TW_A);
    localparam logic [AW:0]   TW_B_X = (AW+1)'(TW_B);
    localparam logic [DV_W-1:0] D_W  = DV_W'(DIV_D);
    localparam logic [DV_W-1:0] RND_W = DV_W'(RND_ADD);
    localparam logic [32:0]   RCP_W  = 33'(RCP);

    // control
    logic [3:0]    state_reg, state_next;
    logic [AW-1:0] fill_reg, fill_next;
    logic [AW-1:0] m_reg, m_next;
    logic [AW-1:0] r_reg, r_next;
    logic [1:0]    quad_reg, quad_next;
    rdft_pkg::z_t  zq_reg, zq_next;
    logic [AW-1:0] zr_reg, zr_next;
    logic [rdft_pkg::STEP_W-1:0] step_reg, step_next;
    logic [AW-1:0] k_reg, k_next;
    logic [AW:0]   xi_reg, xi_next;
    logic          rd_v_reg, pr_v_reg;

    // datapath
    rdft_pkg::xy_t x_reg, x_next, y_reg, y_next;
    rdft_pkg::z_t  z_reg, z_next;
    logic signed [33:0] pa_reg, pb_reg;
    logic signed [ACC_W-1:0] acc_a_reg, acc_a_next, acc_b_reg, acc_b_next;
    logic [31:0]   num_a_reg, num_a_next, num_b_reg, num_b_next;
    logic [24:0]   qa_reg, qa_next, qb_reg, qb_next;
    logic          sat_a_reg, sat_a_next, sat_b_reg, sat_b_next;
    logic          neg_a_reg, neg_a_next, neg_b_reg, neg_b_next;
    rdft_pkg::part_t re_reg, re_next, im_reg, im_next;
    logic [49:0]   sqa_reg, sqa_next, sqb_reg, sqb_next, sq_reg, sq_next;
    logic [49:0]   sv_reg, sv_next, sres_reg, sres_next, bit_reg, bit_next;
    logic [rdft_pkg::MAG_W-1:0] mag_reg, mag_next;
    rdft_pkg::phase_t phase_reg, phase_next;
    logic          pv_reg, pv_next;

    // memories
    logic          smp_we;
    logic [15:0]   smp_rd;
    logic          tw_we;
    logic [35:0]   tw_wdata, tw_rd;

    logic          issue;
    logic signed [15:0] smp_s;
    rdft_pkg::tw_t tw_c, tw_s;

    // shared cordic step
    rdft_pkg::xy_t dx, dy;
    rdft_pkg::z_t  atan_v;
    logic          rot_up;

    function automatic rdft_pkg::tw_t tw_round(input rdft_pkg::xy_t v);
        rdft_pkg::xy_t t;
        t = (v + 48'sd8192) >>> 14;
        if (t > 48'sd65536)
        begin
            return rdft_pkg::TW_LIM;
        end
        if (t < -48'sd65536)
        begin
            return -rdft_pkg::TW_LIM;
        end
        return rdft_pkg::TW_W'(t);
    endfunction

    function automatic rdft_pkg::part_t part_fix(input logic [24:0] q, input logic sat,
                                                 input logic neg);
        logic [24:0] v;
        v = (sat || (q > rdft_pkg::PART_LIM_U)) ? rdft_pkg::PART_LIM_U : q;
        return neg ? -rdft_pkg::PART_W'({1'b0, v}) : rdft_pkg::PART_W'({1'b0, v});
    endfunction

    rdft_ram #(.WIDTH(16), .DEPTH(FRAME_LEN)) u_sample_ram (
        .clk     (clk),
        .wr_en   (smp_we),
        .wr_addr (fill_reg),
        .wr_data (sample),
        .rd_addr (xi_reg[AW-1:0]),
        .rd_data (smp_rd)
    );

    rdft_ram #(.WIDTH(36), .DEPTH(FRAME_LEN)) u_twiddle_ram (
        .clk     (clk),
        .wr_en   (tw_we),
        .wr_addr (m_reg),
        .wr_data (tw_wdata),
        .rd_addr (m_reg),
        .rd_data (tw_rd)
    );

    assign busy   = (state_reg != S_IDLE);
    assign smp_we = start && !busy;
    assign issue  = (state_reg == S_MAC) && (xi_reg < N_X);
    assign smp_s  = $signed(smp_rd);
    assign tw_c   = $signed(tw_rd[35:18]);
    assign tw_s   = $signed(tw_rd[17:0]);

    // one cordic micro-rotation, rotation mode during table build, vectoring for phase
    assign dx     = y_reg >>> step_reg;
    assign dy     = x_reg >>> step_reg;
    assign atan_v = rdft_pkg::atan_q30(step_reg);
    assign rot_up = (state_reg == S_INIT_ROT) ? !z_reg[Z_W-1] : y_reg[XY_W-1];

    // twiddle placement by quadrant
    always_comb
    begin
        rdft_pkg::tw_t cq, sq;
        cq = tw_round(x_reg);
        sq = tw_round(y_reg);
        case (quad_reg)
            2'd0:    tw_wdata = {cq, sq};
            2'd1:    tw_wdata = {-sq, cq};
            2'd2:    tw_wdata = {-cq, -sq};
            default: tw_wdata = {sq, -cq};
        endcase
    end
    assign tw_we = (state_reg == S_INIT_WR);

    always_comb
    begin
        logic [AW+1:0] r4;
        logic [1:0]    j;
        logic [AW:0]   zr_sum;
        logic          zc;
        logic [AW:0]   mk;
        logic signed [ACC_W:0] pa_s, pb_s;
        logic [ACC_W:0] abs_a, abs_b;
        logic [DV_W-1:0] mag_a, mag_b;
        logic [31:0]   dnum;
        logic [64:0]   dprod;
        logic [24:0]   dq;
        logic [49:0]   st;
        logic [49:0]   res1;
        rdft_pkg::part_t re_abs;
        rdft_pkg::z_t  zf, zrd;

        state_next = state_reg;
        fill_next  = fill_reg;
        m_next     = m_reg;
        r_next     = r_reg;
        quad_next  = quad_reg;
        zq_next    = zq_reg;
        zr_next    = zr_reg;
        step_next  = step_reg;
        k_next     = k_reg;
        xi_next    = xi_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        z_next     = z_reg;
        acc_a_next = acc_a_reg;
        acc_b_next = acc_b_reg;
        num_a_next = num_a_reg;
        num_b_next = num_b_reg;
        qa_next    = qa_reg;
        qb_next    = qb_reg;
        sat_a_next = sat_a_reg;
        sat_b_next = sat_b_reg;
        neg_a_next = neg_a_reg;
        neg_b_next = neg_b_reg;
        re_next    = re_reg;
        im_next    = im_reg;
        sqa_next   = sqa_reg;
        sqb_next   = sqb_reg;
        sq_next    = sq_reg;
        sv_next    = sv_reg;
        sres_next  = sres_reg;
        bit_next   = bit_reg;
        mag_next   = mag_reg;
        phase_next = phase_reg;
        pv_next    = pv_reg;

        // table index bookkeeping: 4m = quad*N + r, zq = floor(HALF_PI_Q30 * r / N)
        r4 = {2'b00, r_reg} + (AW+2)'(4);
        if (r4 >= N2_R)
        begin
            j = 2'd2;
        end
        else if (r4 >= N_R)
        begin
            j = 2'd1;
        end
        else
        begin
            j = 2'd0;
        end
        zr_sum = {1'b0, zr_reg} + TW_B_X;
        zc     = (zr_sum >= N_X);
        mk     = {1'b0, m_reg} + {1'b0, k_reg};
        if (mk >= N_X)
        begin
            mk = mk - N_X;
        end

        pa_s  = (k_reg == '0 || k_reg == K_LAST) ? (ACC_W+1)'(acc_a_reg)
                                                 : {acc_a_reg, 1'b0};
        pb_s  = {acc_b_reg, 1'b0};
        abs_a = pa_s[ACC_W] ? $unsigned(-pa_s) : $unsigned(pa_s);
        abs_b = pb_s[ACC_W] ? $unsigned(-pb_s) : $unsigned(pb_s);
        mag_a = DV_W'(abs_a) + RND_W;
        mag_b = DV_W'(abs_b) + RND_W;

        // shared reciprocal multiply: part a on even steps, part b on odd steps
        dnum  = step_reg[0] ? num_b_reg : num_a_reg;
        dprod = 65'(dnum) * 65'(RCP_W);
        dq    = dprod[RCP_SH +: 25];

        st     = sres_reg + bit_reg;
        res1   = (sv_reg > sres_reg) ? sres_reg + 50'd1 : sres_reg;
        re_abs = re_reg[rdft_pkg::PART_W-1] ? -re_reg : re_reg;

        if (re_reg[rdft_pkg::PART_W-1])
        begin
            zf = im_reg[rdft_pkg::PART_W-1] ? -rdft_pkg::PI_Q30 - z_reg
                                            : rdft_pkg::PI_Q30 - z_reg;
        end
        else
        begin
            zf = z_reg;
        end
        zrd = (zf + 36'sd65536) >>> 17;

        unique case (state_reg)
            S_INIT_LOAD:
            begin
                x_next    = rdft_pkg::CORDIC_K;
                y_next    = '0;
                z_next    = zq_reg;
                step_next = '0;
                state_next = S_INIT_ROT;
            end
            S_INIT_ROT, S_PH_ROT:
            begin
                if (rot_up)
                begin
                    x_next = x_reg - dx;
                    y_next = y_reg + dy;
                    z_next = z_reg - atan_v;
                end
                else
                begin
                    x_next = x_reg + dx;
                    y_next = y_reg - dy;
                    z_next = z_reg + atan_v;
                end
                step_next = step_reg + 1'b1;
                if (step_reg == rdft_pkg::STEP_W'(rdft_pkg::CORDIC_LAST))
                begin
                    state_next = (state_reg == S_INIT_ROT) ? S_INIT_WR : S_PH_END;
                end
            end
            S_INIT_WR:
            begin
                m_next    = m_reg + 1'b1;
                quad_next = quad_reg + j;
                r_next    = AW'(r4 - ((j == 2'd2) ? N2_R : ((j == 2'd1) ? N_R : '0)));
                zr_next   = zc ? AW'(zr_sum - N_X) : AW'(zr_sum);
                zq_next   = zq_reg + TW_A_Z + (zc ? 36'sd1 : 36'sd0)
                          - ((j == 2'd2) ? rdft_pkg::PI_Q30
                          : ((j == 2'd1) ? rdft_pkg::HALF_PI_Q30 : 36'sd0));
                if (m_reg == N_LAST)
                begin
                    m_next     = '0;
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_INIT_LOAD;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    if (fill_reg == N_LAST)
                    begin
                        fill_next  = '0;
                        k_next     = '0;
                        xi_next    = '0;
                        m_next     = '0;
                        acc_a_next = '0;
                        acc_b_next = '0;
                        state_next = S_MAC;
                    end
                    else
                    begin
                        fill_next = fill_reg + 1'b1;
                    end
                end
            end
            S_MAC:
            begin
                if (issue)
                begin
                    xi_next = xi_reg + 1'b1;
                    m_next  = AW'(mk);
                end
                if (pr_v_reg)
                begin
                    acc_a_next = acc_a_reg + ACC_W'(pa_reg);
                    acc_b_next = acc_b_reg + ACC_W'(pb_reg);
                end
                if (xi_reg == N_X && !rd_v_reg && !pr_v_reg)
                begin
                    state_next = S_DIV_LOAD;
                end
            end
            S_DIV_LOAD:
            begin
                // divide by 256 is a shift, the rest is a divide by N
                neg_a_next = pa_s[ACC_W];
                neg_b_next = pb_s[ACC_W];
                num_a_next = 32'(mag_a >> 8);
                num_b_next = 32'(mag_b >> 8);
                sat_a_next = (mag_a >= (D_W << 25));
                sat_b_next = (mag_b >= (D_W << 25));
                step_next  = '0;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (step_reg[0])
                begin
                    qb_next    = dq;
                    state_next = S_FIX;
                end
                else
                begin
                    qa_next = dq;
                end
                step_next = step_reg + 1'b1;
            end
            S_FIX:
            begin
                re_next    = part_fix(qa_reg, sat_a_reg, neg_a_reg);
                im_next    = part_fix(qb_reg, sat_b_reg, neg_b_reg);
                state_next = S_SQ1;
            end
            S_SQ1:
            begin
                sqa_next   = 50'($unsigned(52'(re_reg) * 52'(re_reg)));
                state_next = S_SQ2;
            end
            S_SQ2:
            begin
                sqb_next   = 50'($unsigned(52'(im_reg) * 52'(im_reg)));
                state_next = S_SQ3;
            end
            S_SQ3:
            begin
                sq_next    = sqa_reg + sqb_reg;
                sv_next    = sqa_reg + sqb_reg;
                sres_next  = '0;
                bit_next   = 50'd1 << 48;
                step_next  = '0;
                state_next = S_SQRT;
            end
            S_SQRT:
            begin
                if (sv_reg >= st)
                begin
                    sv_next   = sv_reg - st;
                    sres_next = (sres_reg >> 1) + bit_reg;
                end
                else
                begin
                    sres_next = sres_reg >> 1;
                end
                bit_next  = bit_reg >> 2;
                step_next = step_reg + 1'b1;
                if (step_reg == 5'd24)
                begin
                    state_next = S_PH_LOAD;
                end
            end
            S_PH_LOAD:
            begin
                mag_next  = (res1 > 50'(rdft_pkg::MAG_LIM)) ? rdft_pkg::MAG_LIM
                                                            : rdft_pkg::MAG_W'(res1);
                x_next    = XY_W'(re_abs) <<< 20;
                y_next    = XY_W'(im_reg) <<< 20;
                z_next    = '0;
                step_next = '0;
                pv_next   = 1'b1;
                if (re_reg == '0 && im_reg == '0)
                begin
                    phase_next = '0;
                    pv_next    = 1'b0;
                    state_next = S_OUT;
                end
                else if (re_reg == '0)
                begin
                    phase_next = im_reg[rdft_pkg::PART_W-1] ? -rdft_pkg::HALF_PI_Q13
                                                            : rdft_pkg::HALF_PI_Q13;
                    state_next = S_OUT;
                end
                else if (im_reg == '0)
                begin
                    phase_next = re_reg[rdft_pkg::PART_W-1] ? rdft_pkg::PHASE_LIM : '0;
                    state_next = S_OUT;
                end
                else
                begin
                    state_next = S_PH_ROT;
                end
            end
            S_PH_END:
            begin
                if (zrd > 36'(rdft_pkg::PHASE_LIM))
                begin
                    phase_next = rdft_pkg::PHASE_LIM;
                end
                else if (zrd < -36'(rdft_pkg::PHASE_LIM))
                begin
                    phase_next = -rdft_pkg::PHASE_LIM;
                end
                else
                begin
                    phase_next = rdft_pkg::PHASE_W'(zrd);
                end
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (k_reg == K_LAST)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    k_next     = k_reg + 1'b1;
                    xi_next    = '0;
                    m_next     = '0;
                    acc_a_next = '0;
                    acc_b_next = '0;
                    state_next = S_MAC;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT_LOAD;
            fill_reg  <= '0;
            m_reg     <= '0;
            r_reg     <= '0;
            quad_reg  <= '0;
            zq_reg    <= '0;
            zr_reg    <= '0;
            step_reg  <= '0;
            k_reg     <= '0;
            xi_reg    <= '0;
            rd_v_reg  <= 1'b0;
            pr_v_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            m_reg     <= m_next;
            r_reg     <= r_next;
            quad_reg  <= quad_next;
            zq_reg    <= zq_next;
            zr_reg    <= zr_next;
            step_reg  <= step_next;
            k_reg     <= k_next;
            xi_reg    <= xi_next;
            rd_v_reg  <= issue;
            pr_v_reg  <= rd_v_reg;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (rd_v_reg)
        begin
            pa_reg <= smp_s * tw_c;
            pb_reg <= smp_s * tw_s;
        end
        x_reg     <= x_next;
        y_reg     <= y_next;
        z_reg     <= z_next;
        acc_a_reg <= acc_a_next;
        acc_b_reg <= acc_b_next;
        num_a_reg <= num_a_next;
        num_b_reg <= num_b_next;
        qa_reg    <= qa_next;
        qb_reg    <= qb_next;
        sat_a_reg <= sat_a_next;
        sat_b_reg <= sat_b_next;
        neg_a_reg <= neg_a_next;
        neg_b_reg <= neg_b_next;
        re_reg    <= re_next;
        im_reg    <= im_next;
        sqa_reg   <= sqa_next;
        sqb_reg   <= sqb_next;
        sq_reg    <= sq_next;
        sv_reg    <= sv_next;
        sres_reg  <= sres_next;
        bit_reg   <= bit_next;
        mag_reg   <= mag_next;
        phase_reg <= phase_next;
        pv_reg    <= pv_next;
    end

    // result ports, held from registers and strobed in the output state
    assign result_strobe = (state_reg == S_OUT);
    assign bin_index     = rdft_pkg::BIN_W'(k_reg);
    assign real_part     = re_reg;
    assign imag_part     = im_reg;
    assign magnitude     = mag_reg;
    assign power         = rdft_pkg::POW_W'((sq_reg + 50'd32768) >> 16);
    assign phase         = phase_reg;
    assign phase_valid   = pv_reg;
    assign last_bin      = (k_reg == K_LAST);

    // a result transfer only happens inside a frame computation
    a_strobe_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe |-> busy)
        else $error("result strobe outside computation");

    // the final bin hands the block back to sample loading
    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (result_strobe && last_bin) |=> !busy)
        else $error("block still busy after last bin");

    // phase flag cleared exactly when both parts are zero
    a_phase_flag: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe |-> (phase_valid == (real_part != '0 || imag_part != '0)))
        else $error("phase_valid does not match the parts");

    // an undefined phase reads as zero
    a_phase_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_strobe && !phase_valid) |-> (phase == '0))
        else $error("nonzero phase with phase_valid low");

endmodule
